// ----- hdl/sia_pkg.sv -----
// Shared types, widths and helpers for the segment intersection pipeline.
`timescale 1ns / 1ps
package sia_pkg;

    localparam int CW   = 16;           // coordinate width, signed Q12.4
    localparam int DW   = CW + 1;       // endpoint difference
    localparam int PW   = 2 * CW + 1;   // pa / pb cross products
    localparam int DETW = 2 * DW + 1;   // determinant
    localparam int NW   = PW + DW + 1;  // numerators, quotient magnitude
    localparam int RW   = DETW + 1;     // divider partial remainder

    typedef struct packed {
        logic signed [CW-1:0] seg_a_start_x;
        logic signed [CW-1:0] seg_a_start_y;
        logic signed [CW-1:0] seg_a_end_x;
        logic signed [CW-1:0] seg_a_end_y;
        logic signed [CW-1:0] seg_b_start_x;
        logic signed [CW-1:0] seg_b_start_y;
        logic signed [CW-1:0] seg_b_end_x;
        logic signed [CW-1:0] seg_b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } t_seg_out;

    // side data that rides along the divider
    typedef struct packed {
        t_seg_in seg;
        logic    dzero;
        logic    neg_x;
        logic    neg_y;
    } t_tag;

    // front end to divider
    typedef struct packed {
        t_tag            tag;
        logic [NW-1:0]   nx_mag;
        logic [NW-1:0]   ny_mag;
        logic [DETW-1:0] d_mag;
    } t_num;

endpackage

// ----- hdl/sia_front.sv -----
// Front end: differences, determinant and numerators over six register stages.
`timescale 1ns / 1ps
module sia_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sia_pkg::t_seg_in  i_seg,
    output logic              o_valid,
    output sia_pkg::t_num     o_num
);
    localparam int CW   = sia_pkg::CW;
    localparam int DW   = sia_pkg::DW;
    localparam int PW   = sia_pkg::PW;
    localparam int DETW = sia_pkg::DETW;
    localparam int NW   = sia_pkg::NW;

    logic [5:0] r_v;

    // stage 1: deltas
    sia_pkg::t_seg_in r1_seg;
    logic signed [DW-1:0] r1_dxa, r1_dya, r1_dxb, r1_dyb;
    // stage 2: first products
    sia_pkg::t_seg_in r2_seg;
    logic signed [DW-1:0] r2_dxa, r2_dya, r2_dxb, r2_dyb;
    logic signed [2*DW-1:0] r2_dd0, r2_dd1;
    logic signed [2*CW-1:0] r2_pa0, r2_pa1, r2_pb0, r2_pb1;
    // stage 3: d, pa, pb
    sia_pkg::t_seg_in r3_seg;
    logic signed [DW-1:0] r3_dxa, r3_dya, r3_dxb, r3_dyb;
    logic signed [DETW-1:0] r3_d;
    logic signed [PW-1:0] r3_pa, r3_pb;
    // stage 4: numerator products
    sia_pkg::t_seg_in r4_seg;
    logic signed [DETW-1:0] r4_d;
    logic signed [PW+DW-1:0] r4_x0, r4_x1, r4_y0, r4_y1;
    // stage 5: numerators
    sia_pkg::t_seg_in r5_seg;
    logic signed [DETW-1:0] r5_d;
    logic signed [NW-1:0] r5_nx, r5_ny;
    // stage 6: magnitudes and signs
    sia_pkg::t_num r6_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_seg <= i_seg;
        r1_dxa <= DW'(i_seg.seg_a_start_x) - DW'(i_seg.seg_a_end_x);
        r1_dya <= DW'(i_seg.seg_a_start_y) - DW'(i_seg.seg_a_end_y);
        r1_dxb <= DW'(i_seg.seg_b_start_x) - DW'(i_seg.seg_b_end_x);
        r1_dyb <= DW'(i_seg.seg_b_start_y) - DW'(i_seg.seg_b_end_y);

        r2_seg <= r1_seg;
        r2_dxa <= r1_dxa;
        r2_dya <= r1_dya;
        r2_dxb <= r1_dxb;
        r2_dyb <= r1_dyb;
        r2_dd0 <= (2*DW)'(r1_dxa) * (2*DW)'(r1_dyb);
        r2_dd1 <= (2*DW)'(r1_dya) * (2*DW)'(r1_dxb);
        r2_pa0 <= (2*CW)'(r1_seg.seg_a_start_x) * (2*CW)'(r1_seg.seg_a_end_y);
        r2_pa1 <= (2*CW)'(r1_seg.seg_a_start_y) * (2*CW)'(r1_seg.seg_a_end_x);
        r2_pb0 <= (2*CW)'(r1_seg.seg_b_start_x) * (2*CW)'(r1_seg.seg_b_end_y);
        r2_pb1 <= (2*CW)'(r1_seg.seg_b_start_y) * (2*CW)'(r1_seg.seg_b_end_x);

        r3_seg <= r2_seg;
        r3_dxa <= r2_dxa;
        r3_dya <= r2_dya;
        r3_dxb <= r2_dxb;
        r3_dyb <= r2_dyb;
        r3_d   <= DETW'(r2_dd0) - DETW'(r2_dd1);
        r3_pa  <= PW'(r2_pa0) - PW'(r2_pa1);
        r3_pb  <= PW'(r2_pb0) - PW'(r2_pb1);

        r4_seg <= r3_seg;
        r4_d   <= r3_d;
        r4_x0  <= (PW+DW)'(r3_pa) * (PW+DW)'(r3_dxb);
        r4_x1  <= (PW+DW)'(r3_dxa) * (PW+DW)'(r3_pb);
        r4_y0  <= (PW+DW)'(r3_pa) * (PW+DW)'(r3_dyb);
        r4_y1  <= (PW+DW)'(r3_dya) * (PW+DW)'(r3_pb);

        r5_seg <= r4_seg;
        r5_d   <= r4_d;
        r5_nx  <= NW'(r4_x0) - NW'(r4_x1);
        r5_ny  <= NW'(r4_y0) - NW'(r4_y1);

        r6_num.tag.seg   <= r5_seg;
        r6_num.tag.dzero <= (r5_d == '0);
        r6_num.tag.neg_x <= r5_nx[NW-1] ^ r5_d[DETW-1];
        r6_num.tag.neg_y <= r5_ny[NW-1] ^ r5_d[DETW-1];
        r6_num.nx_mag    <= r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
        r6_num.ny_mag    <= r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
        r6_num.d_mag     <= r5_d[DETW-1] ? DETW'(-r5_d) : DETW'(r5_d);
    end

    assign o_valid = r_v[5];
    assign o_num   = r6_num;

endmodule

// ----- hdl/sia_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel.
`timescale 1ns / 1ps
module sia_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  sia_pkg::t_num            i_num,
    output logic                     o_valid,
    output sia_pkg::t_tag            o_tag,
    output logic [sia_pkg::NW-1:0]   o_qx,
    output logic [sia_pkg::NW-1:0]   o_qy
);
    localparam int NW   = sia_pkg::NW;
    localparam int RW   = sia_pkg::RW;
    localparam int DETW = sia_pkg::DETW;

    logic                r_v   [NW];
    sia_pkg::t_tag       r_tag [NW];
    logic [DETW-1:0]     r_dv  [NW];
    logic [RW-1:0]       r_rx  [NW];
    logic [RW-1:0]       r_ry  [NW];
    logic [NW-1:0]       r_nx  [NW];
    logic [NW-1:0]       r_ny  [NW];
    logic [NW-1:0]       r_qx  [NW];
    logic [NW-1:0]       r_qy  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic                pv;
        sia_pkg::t_tag       ptag;
        logic [DETW-1:0]     pdv;
        logic [RW-1:0]       prx, pry, shx, shy, n_rx, n_ry;
        logic [NW-1:0]       pnx, pny, pqx, pqy;
        logic                bx, by;

        if (k == 0) begin : g_first
            assign pv   = i_valid;
            assign ptag = i_num.tag;
            assign pdv  = i_num.d_mag;
            assign prx  = '0;
            assign pry  = '0;
            assign pnx  = i_num.nx_mag;
            assign pny  = i_num.ny_mag;
            assign pqx  = '0;
            assign pqy  = '0;
        end else begin : g_next
            assign pv   = r_v[k-1];
            assign ptag = r_tag[k-1];
            assign pdv  = r_dv[k-1];
            assign prx  = r_rx[k-1];
            assign pry  = r_ry[k-1];
            assign pnx  = r_nx[k-1];
            assign pny  = r_ny[k-1];
            assign pqx  = r_qx[k-1];
            assign pqy  = r_qy[k-1];
        end

        always_comb begin
            shx  = {prx[RW-2:0], pnx[NW-1]};
            shy  = {pry[RW-2:0], pny[NW-1]};
            bx   = (shx >= RW'(pdv));
            by   = (shy >= RW'(pdv));
            n_rx = bx ? shx - RW'(pdv) : shx;
            n_ry = by ? shy - RW'(pdv) : shy;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= ptag;
            r_dv[k]  <= pdv;
            r_rx[k]  <= n_rx;
            r_ry[k]  <= n_ry;
            r_nx[k]  <= {pnx[NW-2:0], 1'b0};
            r_ny[k]  <= {pny[NW-2:0], 1'b0};
            r_qx[k]  <= {pqx[NW-2:0], bx};
            r_qy[k]  <= {pqy[NW-2:0], by};
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_tag   = r_tag[NW-1];
    assign o_qx    = r_qx[NW-1];
    assign o_qy    = r_qy[NW-1];

endmodule

// ----- hdl/segment_intersection_unit.sv -----
// Top level of the 2D segment intersection pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive i_seg with both endpoints of segments A and B
//   (signed Q12.4) and pulse start. A transaction is taken at every rising
//   edge with start high and busy low. busy is always low: the pipeline is
//   fully stall free, so one transaction may enter every cycle.
//   Output channel: o_valid strobes for exactly one cycle with o_result
//   (hit, cross_x, cross_y). Results come out in input order.
// Pipeline: 6 front-end stages (differences, determinant, cross products,
//   numerators, magnitudes), 51 stages of the restoring divider (one
//   quotient bit each, set by the numerator width), 1 output stage.
// Throughput: one transaction per cycle, sustained.
// Reset: synchronous, active low; clears all valid bits so no strobe
//   appears until new transactions arrive. Data registers are not reset.
// The receiver cannot stall: each result is presented once and is gone.
// Parallel or degenerate pairs (zero determinant) and points outside either
// segment's bounding ranges report hit = 0 with zero coordinates.
module segment_intersection_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sia_pkg::t_seg_in   i_seg,
    output logic               busy,
    output logic               o_valid,
    output sia_pkg::t_seg_out  o_result
);
    localparam int CW = sia_pkg::CW;
    localparam int NW = sia_pkg::NW;
    localparam int QW = NW + 1;

    logic               f_valid;
    sia_pkg::t_num      f_num;
    logic               d_valid;
    sia_pkg::t_tag      d_tag;
    logic [NW-1:0]      d_qx, d_qy;

    logic signed [QW-1:0] qx, qy;
    logic hit;

    logic               r_valid;
    sia_pkg::t_seg_out  r_result;

    // never back-pressures
    assign busy = 1'b0;

    sia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_seg   (i_seg),
        .o_valid (f_valid),
        .o_num   (f_num)
    );

    sia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_num   (f_num),
        .o_valid (d_valid),
        .o_tag   (d_tag),
        .o_qx    (d_qx),
        .o_qy    (d_qy)
    );

    // inclusive range test against both endpoints of a segment
    function automatic logic in_range(input logic signed [QW-1:0] v,
                                      input logic signed [CW-1:0] p,
                                      input logic signed [CW-1:0] r);
        logic signed [QW-1:0] pe, re;
        begin
            pe = QW'(p);
            re = QW'(r);
            in_range = ((v >= pe) && (v <= re)) || ((v >= re) && (v <= pe));
        end
    endfunction

    // apply quotient sign (truncation toward zero) and check bounds
    always_comb begin
        qx  = d_tag.neg_x ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
        qy  = d_tag.neg_y ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
        hit = !d_tag.dzero
            && in_range(qx, d_tag.seg.seg_a_start_x, d_tag.seg.seg_a_end_x)
            && in_range(qx, d_tag.seg.seg_b_start_x, d_tag.seg.seg_b_end_x)
            && in_range(qy, d_tag.seg.seg_a_start_y, d_tag.seg.seg_a_end_y)
            && in_range(qy, d_tag.seg.seg_b_start_y, d_tag.seg.seg_b_end_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.hit     <= hit;
        r_result.cross_x <= hit ? qx[CW-1:0] : '0;
        r_result.cross_y <= hit ? qy[CW-1:0] : '0;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
